// ----- src/cuc_pkg.sv -----
// Types, constants and the saturated binomial helper shared by the colex unrank block.
package cuc_pkg;

  localparam int RankW  = 34;
  localparam int SizeW  = 6;
  localparam int MaskW  = 36;
  localparam int BinomW = RankW + 1;
  localparam int TabN   = 64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_BAD_RANK = 2'd2
  } status_e;

  typedef struct packed {
    logic [RankW-1:0] rank_in;
    logic [SizeW-1:0] universe_size;
    logic [SizeW-1:0] set_size;
  } req_t;

  typedef struct packed {
    logic [MaskW-1:0] pattern_mask;
    status_e          status;
  } res_t;

  // C(n,k) saturated at 2^RankW, which is above any rank; elaboration use only.
  function automatic logic [BinomW-1:0] binom_sat(input int n, input int k);
    logic [BinomW:0] row [0:TabN-1];
    logic [BinomW:0] sum;
    logic [BinomW:0] cap;
    int a;
    int b;
    cap = (BinomW+1)'(1) << RankW;
    for (a = 0; a < TabN; a++) begin
      row[a] = '0;
    end
    row[0] = (BinomW+1)'(1);
    for (a = 1; a <= n; a++) begin
      for (b = a; b >= 1; b--) begin
        sum    = row[b] + row[b-1];
        row[b] = (sum > cap) ? cap : sum;
      end
    end
    return row[k][BinomW-1:0];
  endfunction

endpackage

// ----- src/combination_unrank_colex.sv -----
// Top level: pipelined colex unrank of a combination, one position per stage.
//
// Usage: present a request on req_i and raise start_i; it is taken at a rising edge
// where start_i is high and busy_o is low. busy_o is high only while reset is
// applied and for the first cycle after release; after that a request may be issued
// in every cycle.
// Each request yields one result on res_o, marked by valid_o for exactly one
// cycle, once it has passed the input register, one stage per position from the
// highest down to zero, and the output register. Throughput is one request per
// cycle; each position stage holds one rank compare and one 34-bit subtract.
// The receiver cannot stall, so the pipeline always advances.
// Status: ok, invalid sizes (universe above MAX_POSITIONS or set above universe),
// or rank out of range (nonzero leftover rank after the last stage). A set size
// of zero returns ok with an empty mask for any universe. The mask is zero on error.
// Reset (rst_ni low, asynchronous) drops every request in flight.
module combination_unrank_colex #(
  parameter int MAX_POSITIONS = 36
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cuc_pkg::req_t req_i,
  output logic          valid_o,
  output cuc_pkg::res_t res_o
);

  localparam int NStg = MAX_POSITIONS + 1;

  logic                        busy_q;
  logic                        vld_q  [0:NStg-1];
  logic [cuc_pkg::RankW-1:0]   rank_q [0:NStg-1];
  logic [cuc_pkg::SizeW-1:0]   cnt_q  [0:NStg-1];
  logic [cuc_pkg::SizeW-1:0]   univ_q [0:NStg-1];
  logic [MAX_POSITIONS-1:0]    mask_q [0:NStg-1];
  cuc_pkg::status_e            pre_q  [0:NStg-1];

  logic                        accept;
  logic                        empty_set;
  logic                        bad_size;

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  // Entry stage: size checks; early results run through with no count and no rank.
  assign empty_set = (req_i.set_size == '0);
  assign bad_size  = (req_i.universe_size > cuc_pkg::SizeW'(MAX_POSITIONS)) ||
                     (req_i.set_size > req_i.universe_size);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    univ_q[0] <= req_i.universe_size;
    mask_q[0] <= '0;
    if (empty_set || bad_size) begin
      rank_q[0] <= '0;
      cnt_q[0]  <= '0;
      pre_q[0]  <= empty_set ? cuc_pkg::ST_OK : cuc_pkg::ST_BAD_SIZE;
    end else begin
      rank_q[0] <= req_i.rank_in;
      cnt_q[0]  <= req_i.set_size;
      pre_q[0]  <= cuc_pkg::ST_OK;
    end
  end

  // Stage j decides position MAX_POSITIONS - j.
  for (genvar j = 1; j < NStg; j++) begin : g_stage
    localparam int Pos = MAX_POSITIONS - j;

    logic [cuc_pkg::BinomW-1:0] col [0:cuc_pkg::TabN-1];
    logic [cuc_pkg::BinomW-1:0] coef;
    logic                       take;

    for (genvar k = 0; k < cuc_pkg::TabN; k++) begin : g_col
      assign col[k] = cuc_pkg::binom_sat(Pos, k);
    end

    assign coef = col[cnt_q[j-1]];
    assign take = (cnt_q[j-1] != '0) &&
                  (univ_q[j-1] > cuc_pkg::SizeW'(Pos)) &&
                  (coef <= {1'b0, rank_q[j-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      univ_q[j] <= univ_q[j-1];
      pre_q[j]  <= pre_q[j-1];
      if (take) begin
        rank_q[j] <= rank_q[j-1] - coef[cuc_pkg::RankW-1:0];
        cnt_q[j]  <= cnt_q[j-1] - cuc_pkg::SizeW'(1);
        mask_q[j] <= mask_q[j-1] | (MAX_POSITIONS'(1) << Pos);
      end else begin
        rank_q[j] <= rank_q[j-1];
        cnt_q[j]  <= cnt_q[j-1];
        mask_q[j] <= mask_q[j-1];
      end
    end
  end

  // Output stage: leftover rank means the rank was past C(P,S).
  logic [cuc_pkg::MaskW-1:0] mask_ext;
  cuc_pkg::status_e          status_d;
  logic                      valid_q;
  cuc_pkg::res_t             res_q;

  for (genvar b = 0; b < cuc_pkg::MaskW; b++) begin : g_ext
    if (b < MAX_POSITIONS) begin : g_bit
      assign mask_ext[b] = mask_q[NStg-1][b];
    end else begin : g_zero
      assign mask_ext[b] = 1'b0;
    end
  end

  always_comb begin
    if (pre_q[NStg-1] != cuc_pkg::ST_OK) begin
      status_d = pre_q[NStg-1];
    end else if (rank_q[NStg-1] != '0) begin
      status_d = cuc_pkg::ST_BAD_RANK;
    end else begin
      status_d = cuc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.status       <= status_d;
    res_q.pattern_mask <= (status_d == cuc_pkg::ST_OK) ? mask_ext : '0;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- src/cuc_checker.sv -----
// Port-level checker for the colex unrank block, bound to the top level.
module cuc_assertions #(
  parameter int MAX_POSITIONS = 36
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input cuc_pkg::req_t req_i,
  input logic          valid_o,
  input cuc_pkg::res_t res_o
);

  localparam int Lat = MAX_POSITIONS + 2;

  // Every taken request comes back as one result strobe, and nothing else does.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(start_i && !busy_o, Lat))
    else $error("result strobe does not match a request taken %0d cycles earlier", Lat);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (res_o.status != cuc_pkg::ST_OK) |-> res_o.pattern_mask == '0)
    else $error("error result carries a nonzero mask");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.status == cuc_pkg::ST_OK) || (res_o.status == cuc_pkg::ST_BAD_SIZE) ||
                (res_o.status == cuc_pkg::ST_BAD_RANK))
    else $error("unknown status code");

  a_popcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (res_o.status == cuc_pkg::ST_OK) |->
      $countones(res_o.pattern_mask) == int'($past(req_i.set_size, Lat)))
    else $error("mask population differs from the requested set size");

  a_in_universe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (res_o.status == cuc_pkg::ST_OK) |->
      (res_o.pattern_mask >> $past(req_i.universe_size, Lat)) == '0)
    else $error("mask has a position outside the universe");

endmodule

bind combination_unrank_colex cuc_assertions #(
  .MAX_POSITIONS(MAX_POSITIONS)
) u_cuc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .valid_o (valid_o),
  .res_o   (res_o)
);
